// File: design/assert_macros.svh
// Assertion macros shared by the sieve table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: design/sps_pkg.sv
// Package for the segmented prime sieve table: defaults and field widths.
package sps_pkg;
    localparam int SEGMENT_BITS_DEF = 1024;
    localparam int TABLE_DEPTH_DEF  = 4096;
    localparam int PRIME_WIDTH_DEF  = 32;
    localparam int POS_W            = 12;
    localparam int VALUE_W          = 32;
    localparam int STATUS_W         = 1;
    localparam logic [STATUS_W-1:0] STATUS_OK  = 1'b0;
    localparam logic [STATUS_W-1:0] STATUS_ERR = 1'b1;
endpackage

// File: design/sps_rem.sv
// Iterative restoring remainder unit, one quotient bit per cycle.
module sps_rem #(
    parameter int W = 40
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    output logic         done,
    output logic [W-1:0] remainder
);
    localparam int CNTW = $clog2(W + 1);

    logic            run_reg, run_next;
    logic            done_reg, done_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic [W-1:0]    rem_reg, rem_next;
    logic [W-1:0]    sh_reg, sh_next;
    logic [W-1:0]    dv_reg, dv_next;
    logic [W:0]      trial;

    // one shift and compare-subtract step
    always_comb
    begin
        trial     = {rem_reg, sh_reg[W-1]};
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        sh_next   = sh_reg;
        dv_next   = dv_reg;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = '0;
            rem_next = '0;
            sh_next  = dividend;
            dv_next  = divisor;
        end
        else if (run_reg)
        begin
            if (trial >= {1'b0, dv_reg})
                rem_next = W'(trial - {1'b0, dv_reg});
            else
                rem_next = trial[W-1:0];
            sh_next  = {sh_reg[W-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNTW'(W - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        sh_reg  <= sh_next;
        dv_reg  <= dv_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;
endmodule

// File: design/segmented_prime_sieve_table.sv
// Segmented prime sieve table: top level with controller, prime store and segment marks.
//
// A request (start while busy is low) asks for the prime at a zero-based position; the
// word comes back on prime_value and status with done high for one cycle, and the block
// cannot be stalled on its result side. A position already in the table is served by
// one read of the prime store. Otherwise the table grows one segment at a time: seed 2
// and 3 on the first growth, clear the mark memory, then for each stored odd prime find
// its first odd multiple in the segment with the remainder unit and write its marks,
// then scan the segment bits one by one and, for each new prime, write its marks. The
// mark memory and the bit-serial remainder unit set the growth time; a position at or
// beyond TABLE_DEPTH is answered at once with status 1, and a position that the table
// cannot grow to is also answered with status 1.
module segmented_prime_sieve_table #(
    parameter int SEGMENT_BITS = sps_pkg::SEGMENT_BITS_DEF,
    parameter int TABLE_DEPTH  = sps_pkg::TABLE_DEPTH_DEF,
    parameter int PRIME_WIDTH  = sps_pkg::PRIME_WIDTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [sps_pkg::POS_W-1:0]   wanted_position,
    output logic                        done,
    output logic [sps_pkg::VALUE_W-1:0] prime_value,
    output logic [sps_pkg::STATUS_W-1:0] status
);
    import sps_pkg::*;
    `include "assert_macros.svh"

    localparam int AW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW   = $clog2(TABLE_DEPTH + 1);
    localparam int CMPW = ((CW > POS_W) ? CW : POS_W) + 1;
    localparam int BW   = $clog2(SEGMENT_BITS);
    localparam int VW   = PRIME_WIDTH + BW + 3;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_CHECK  = 4'd1;
    localparam logic [3:0] ST_RWAIT  = 4'd2;
    localparam logic [3:0] ST_SEED   = 4'd3;
    localparam logic [3:0] ST_CLEAR  = 4'd4;
    localparam logic [3:0] ST_BASE   = 4'd5;
    localparam logic [3:0] ST_BWAIT  = 4'd6;
    localparam logic [3:0] ST_DIVGO  = 4'd7;
    localparam logic [3:0] ST_DIVW   = 4'd8;
    localparam logic [3:0] ST_MARKB  = 4'd9;
    localparam logic [3:0] ST_SCAN   = 4'd10;
    localparam logic [3:0] ST_SWAIT  = 4'd11;
    localparam logic [3:0] ST_MARKS  = 4'd12;
    localparam logic [3:0] ST_ENDSEG = 4'd13;

    logic [3:0]             state_reg, state_next;
    logic [CW-1:0]          count_reg, count_next;
    logic [CW-1:0]          base_reg, base_next;
    logic [CW-1:0]          k_reg, k_next;
    logic [BW-1:0]          b_reg, b_next;
    logic [VW-1:0]          j_reg, j_next;
    logic [VW-1:0]          stride_reg, stride_next;
    logic [PRIME_WIDTH-1:0] last_reg, last_next;
    logic [PRIME_WIDTH-1:0] seg_last_reg, seg_last_next;
    logic [PRIME_WIDTH-1:0] p_reg, p_next;
    logic [POS_W-1:0]       pos_reg, pos_next;
    logic                   added_reg, added_next;
    logic                   nogrow_reg, nogrow_next;
    logic                   done_reg, done_next;
    logic [VALUE_W-1:0]     value_reg, value_next;
    logic [STATUS_W-1:0]    status_reg, status_next;

    // prime store ports
    logic [PRIME_WIDTH-1:0] store_mem [TABLE_DEPTH];
    logic                   st_wr_en, st_rd_en;
    logic [AW-1:0]          st_wr_addr, st_rd_addr;
    logic [PRIME_WIDTH-1:0] st_wr_data, st_rd_reg;

    // segment mark ports
    logic                   mark_mem [SEGMENT_BITS];
    logic                   mk_wr_en, mk_rd_en, mk_wr_data, mk_rd_reg;
    logic [BW-1:0]          mk_wr_addr, mk_rd_addr;

    // remainder unit
    logic                   div_start, div_done;
    logic [VW-1:0]          div_a, div_d, div_r;

    logic [CMPW-1:0]        pos_ext, count_ext, in_ext;
    logic [VW-1:0]          cand;
    logic                   cand_fits;

    sps_rem #(.W(VW)) u_rem (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_a),
        .divisor   (div_d),
        .done      (div_done),
        .remainder (div_r)
    );

    assign pos_ext   = CMPW'(pos_reg);
    assign count_ext = CMPW'(count_reg);
    assign in_ext    = CMPW'(wanted_position);
    assign div_a     = VW'(seg_last_reg) + VW'(1) - VW'(p_reg);
    assign div_d     = VW'(p_reg) << 1;
    assign cand      = VW'(seg_last_reg) + VW'(2) + (VW'(b_reg) << 1);
    assign cand_fits = (cand >> PRIME_WIDTH) == '0;

    // controller
    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        base_next     = base_reg;
        k_next        = k_reg;
        b_next        = b_reg;
        j_next        = j_reg;
        stride_next   = stride_reg;
        last_next     = last_reg;
        seg_last_next = seg_last_reg;
        p_next        = p_reg;
        pos_next      = pos_reg;
        added_next    = added_reg;
        nogrow_next   = nogrow_reg;
        done_next     = 1'b0;
        value_next    = value_reg;
        status_next   = status_reg;
        st_wr_en      = 1'b0;
        st_wr_addr    = count_reg[AW-1:0];
        st_wr_data    = '0;
        st_rd_en      = 1'b0;
        st_rd_addr    = pos_ext[AW-1:0];
        mk_wr_en      = 1'b0;
        mk_wr_addr    = b_reg;
        mk_wr_data    = 1'b0;
        mk_rd_en      = 1'b0;
        mk_rd_addr    = b_reg;
        div_start     = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    pos_next    = wanted_position;
                    nogrow_next = 1'b0;
                    if (in_ext >= CMPW'(TABLE_DEPTH))
                    begin
                        done_next   = 1'b1;
                        value_next  = '0;
                        status_next = STATUS_ERR;
                    end
                    else
                        state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (count_ext > pos_ext)
                begin
                    st_rd_en   = 1'b1;
                    state_next = ST_RWAIT;
                end
                else if (nogrow_reg || count_ext >= CMPW'(TABLE_DEPTH))
                begin
                    done_next   = 1'b1;
                    value_next  = '0;
                    status_next = STATUS_ERR;
                    state_next  = ST_IDLE;
                end
                else
                begin
                    added_next = 1'b0;
                    b_next     = '0;
                    if (count_reg < CW'(2))
                        state_next = ST_SEED;
                    else
                        state_next = ST_CLEAR;
                end
            end
            ST_RWAIT:
            begin
                done_next   = 1'b1;
                value_next  = VALUE_W'(st_rd_reg);
                status_next = STATUS_OK;
                state_next  = ST_IDLE;
            end
            ST_SEED:
            begin
                st_wr_en   = 1'b1;
                st_wr_data = (count_reg == '0) ? PRIME_WIDTH'(2) : PRIME_WIDTH'(3);
                count_next = count_reg + 1'b1;
                if (count_reg != '0)
                begin
                    last_next  = PRIME_WIDTH'(3);
                    added_next = 1'b1;
                    state_next = ST_CLEAR;
                end
            end
            ST_CLEAR:
            begin
                mk_wr_en   = 1'b1;
                mk_wr_data = 1'b0;
                if (b_reg == BW'(SEGMENT_BITS - 1))
                begin
                    b_next        = '0;
                    k_next        = CW'(1);
                    base_next     = count_reg;
                    seg_last_next = last_reg;
                    state_next    = ST_BASE;
                end
                else
                    b_next = b_reg + 1'b1;
            end
            ST_BASE:
            begin
                if (k_reg < base_reg)
                begin
                    st_rd_en   = 1'b1;
                    st_rd_addr = k_reg[AW-1:0];
                    state_next = ST_BWAIT;
                end
                else
                begin
                    b_next     = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_BWAIT:
            begin
                p_next     = st_rd_reg;
                state_next = ST_DIVGO;
            end
            ST_DIVGO:
            begin
                if (p_reg == '0 || p_reg > seg_last_reg)
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = ST_BASE;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIVW;
                end
            end
            ST_DIVW:
            begin
                if (div_done)
                begin
                    // first odd multiple above the last prime, as a bit index
                    j_next      = (div_d - div_r - VW'(1)) >> 1;
                    stride_next = VW'(p_reg);
                    state_next  = ST_MARKB;
                end
            end
            ST_MARKB:
            begin
                if (j_reg < VW'(SEGMENT_BITS))
                begin
                    mk_wr_en   = 1'b1;
                    mk_wr_addr = j_reg[BW-1:0];
                    mk_wr_data = 1'b1;
                    j_next     = j_reg + stride_reg;
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = ST_BASE;
                end
            end
            ST_SCAN:
            begin
                mk_rd_en   = 1'b1;
                state_next = ST_SWAIT;
            end
            ST_SWAIT:
            begin
                if (!mk_rd_reg)
                begin
                    // unmarked bit: a prime, kept while there is room and it fits in PRIME_WIDTH
                    if (count_ext < CMPW'(TABLE_DEPTH) && cand_fits)
                    begin
                        st_wr_en   = 1'b1;
                        st_wr_data = cand[PRIME_WIDTH-1:0];
                        count_next = count_reg + 1'b1;
                        last_next  = cand[PRIME_WIDTH-1:0];
                        added_next = 1'b1;
                    end
                    j_next      = VW'(b_reg) + cand;
                    stride_next = cand;
                    state_next  = ST_MARKS;
                end
                else if (b_reg == BW'(SEGMENT_BITS - 1))
                    state_next = ST_ENDSEG;
                else
                begin
                    b_next     = b_reg + 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_MARKS:
            begin
                if (j_reg < VW'(SEGMENT_BITS))
                begin
                    mk_wr_en   = 1'b1;
                    mk_wr_addr = j_reg[BW-1:0];
                    mk_wr_data = 1'b1;
                    j_next     = j_reg + stride_reg;
                end
                else if (b_reg == BW'(SEGMENT_BITS - 1))
                    state_next = ST_ENDSEG;
                else
                begin
                    b_next     = b_reg + 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_ENDSEG:
            begin
                nogrow_next = !added_reg;
                state_next  = ST_CHECK;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        base_reg     <= base_next;
        k_reg        <= k_next;
        b_reg        <= b_next;
        j_reg        <= j_next;
        stride_reg   <= stride_next;
        last_reg     <= last_next;
        seg_last_reg <= seg_last_next;
        p_reg        <= p_next;
        pos_reg      <= pos_next;
        added_reg    <= added_next;
        nogrow_reg   <= nogrow_next;
        value_reg    <= value_next;
        status_reg   <= status_next;
    end

    // prime store memory
    always_ff @(posedge clk)
    begin
        if (st_wr_en)
            store_mem[st_wr_addr] <= st_wr_data;
        if (st_rd_en)
            st_rd_reg <= store_mem[st_rd_addr];
    end

    // segment mark memory
    always_ff @(posedge clk)
    begin
        if (mk_wr_en)
            mark_mem[mk_wr_addr] <= mk_wr_data;
        if (mk_rd_en)
            mk_rd_reg <= mark_mem[mk_rd_addr];
    end

    assign busy        = (state_reg != ST_IDLE);
    assign done        = done_reg;
    assign prime_value = value_reg;
    assign status      = status_reg;

    `ASSERT_IMPL(a_done_idle, clk, rst_n, done, !busy)
    `ASSERT_IMPL(a_err_zero, clk, rst_n, done && status == STATUS_ERR, prime_value == '0)
    `ASSERT_IMPL(a_count_cap, clk, rst_n, 1'b1, count_ext <= CMPW'(TABLE_DEPTH))
    `ASSERT_NEXT(a_accept, clk, rst_n, start && !busy, busy || done)
endmodule

// File: verif/tb_segmented_prime_sieve_table.sv
// Testbench for the segmented prime sieve table: prime requests against a sieve predictor.
module tb_segmented_prime_sieve_table;
    import sps_pkg::*;

    localparam int SEG_BITS     = SEGMENT_BITS_DEF;
    localparam int DEPTH        = TABLE_DEPTH_DEF;
    localparam int PWIDTH       = PRIME_WIDTH_DEF;
    localparam int IDLE_LIMIT   = 20000000;
    localparam int RANDOM_ITEMS = 120;
    localparam int DRAIN_AT     = 12;

    typedef struct packed {
        logic [VALUE_W-1:0]  value;
        logic [STATUS_W-1:0] stat;
    } prime_word_t;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic [POS_W-1:0]    wanted_position;
    logic                done;
    logic [VALUE_W-1:0]  prime_value;
    logic [STATUS_W-1:0] status;

    // own copy of the sieve state
    longint unsigned known_primes[DEPTH];
    int unsigned     known_count;
    bit              seg_marks[SEG_BITS];

    logic [POS_W-1:0] pending_positions[$];
    prime_word_t      awaited_primes[$];
    int unsigned      mismatch_count;
    int unsigned      sent_count;
    int unsigned      burst_left;
    int unsigned      gap_left;
    int unsigned      idle_cycles;
    bit               drain_hold;

    segmented_prime_sieve_table u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .wanted_position (wanted_position),
        .done            (done),
        .prime_value     (prime_value),
        .status          (status)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // append a request position to the pending list
    function automatic void queue_position(logic [POS_W-1:0] pos);
        pending_positions = {pending_positions, pos};
    endfunction

    // append a predicted word to the awaited list
    function automatic void queue_prediction(prime_word_t w);
        awaited_primes = {awaited_primes, w};
    endfunction

    // strike every stride-th mark from first onwards
    function automatic void strike_marks(longint unsigned first, longint unsigned stride);
        longint unsigned j;
        if (stride == 0)
            return;
        for (j = first; j < SEG_BITS; j += stride)
            seg_marks[j] = 1'b1;
    endfunction

    // sieve one segment of odd numbers above the last known prime
    function automatic bit sieve_next_segment();
        longint unsigned last_p;
        longint unsigned lim;
        longint unsigned p;
        longint unsigned q;
        longint unsigned v;
        int unsigned     base_n;
        bit              grew;
        grew = 1'b0;
        lim  = (PWIDTH >= 64) ? ~64'd0 : ((64'd1 << PWIDTH) - 1);
        if (known_count < 2)
        begin
            if (known_count == 0)
            begin
                known_primes[0] = 2;
                known_count = 1;
            end
            known_primes[known_count] = 3;
            known_count++;
            grew = 1'b1;
        end
        foreach (seg_marks[i])
            seg_marks[i] = 1'b0;
        last_p = known_primes[known_count-1];
        base_n = known_count;
        for (int unsigned k = 1; k < base_n; k++)
        begin
            p = known_primes[k];
            if (p == 0 || p > last_p)
                continue;
            q = ((last_p - p + 1) / (2 * p) + 1) * (2 * p) + p;
            strike_marks((q - last_p - 2) / 2, p);
        end
        for (longint unsigned b = 0; b < SEG_BITS; b++)
        begin
            if (!seg_marks[b])
            begin
                v = last_p + 2 + 2 * b;
                if (known_count < DEPTH && v <= lim)
                begin
                    known_primes[known_count] = v;
                    known_count++;
                    grew = 1'b1;
                end
                strike_marks(b + v, v);
            end
        end
        return grew;
    endfunction

    function automatic prime_word_t prime_at(logic [POS_W-1:0] pos);
        prime_word_t w;
        w.value = '0;
        w.stat  = STATUS_ERR;
        if (pos >= DEPTH)
            return w;
        while (known_count <= pos && known_count < DEPTH)
        begin
            if (!sieve_next_segment())
                break;
        end
        if (pos < known_count)
        begin
            w.value = known_primes[pos][VALUE_W-1:0];
            w.stat  = STATUS_OK;
        end
        return w;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        mismatch_count++;
    endtask

    // driver: bursts of requests with random gaps, and one hold until drained
    always @(posedge clk or negedge rst_n)
    begin
        bit               next_start;
        logic [POS_W-1:0] next_pos;
        if (!rst_n)
        begin
            start           <= 1'b0;
            wanted_position <= '0;
            burst_left      = 0;
            gap_left        = 0;
            sent_count      = 0;
            drain_hold      = 1'b0;
        end
        else
        begin
            next_start = start;
            next_pos   = wanted_position;
            if (start && !busy)
            begin
                queue_prediction(prime_at(wanted_position));
                sent_count++;
                next_start = 1'b0;
                if (sent_count == DRAIN_AT)
                    drain_hold = 1'b1;
            end
            if (drain_hold && awaited_primes.size() == 0 && !done)
                drain_hold = 1'b0;
            if (!next_start)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (!drain_hold && pending_positions.size() > 0)
                begin
                    if (burst_left == 0)
                        burst_left = $urandom_range(1, 8);
                    next_start = 1'b1;
                    next_pos   = pending_positions.pop_front();
                    burst_left--;
                    if (burst_left == 0)
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end
            end
            start           <= next_start;
            wanted_position <= next_pos;
        end
    end

    // monitor: each done word against the oldest prediction
    always @(posedge clk)
    begin
        prime_word_t want;
        if (rst_n && done)
        begin
            if (awaited_primes.size() == 0)
                report_mismatch("unexpected word", {prime_value, status}, 0);
            else
            begin
                want = awaited_primes.pop_front();
                if (prime_value !== want.value)
                    report_mismatch("prime_value", prime_value, want.value);
                if (status !== want.stat)
                    report_mismatch("status", status, want.stat);
            end
        end
    end

    // watchdog on cycles without any accepted word
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("watchdog expired with %0d words awaited", awaited_primes.size());
            $display("tb_segmented_prime_sieve_table: FAIL");
            $finish;
        end
    end

    initial
    begin
        logic [POS_W-1:0] directed[] = '{0, 1, 2, 3, 4, 5, 10, 100, 171, 172, 173,
                                          1023, 1024, 2048, 4095, 4094, 2, 0, 7, 2047};
        mismatch_count = 0;
        idle_cycles    = 0;
        rst_n          = 1'b0;
        known_count    = 0;
        foreach (directed[i])
            queue_position(directed[i]);
        // mostly small positions, a few across the full range
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                queue_position(POS_W'($urandom));
            else
                queue_position(POS_W'($urandom_range(0, 600)));
        end
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        wait (pending_positions.size() == 0);
        @(posedge clk);
        while (start || awaited_primes.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatch_count == 0 && awaited_primes.size() == 0)
            $display("tb_segmented_prime_sieve_table: PASS");
        else
            $display("tb_segmented_prime_sieve_table: FAIL");
        $finish;
    end
endmodule
